### sv/ipv4ftc_pkg.sv
// Shared types and constants for the IPv4 flow table counter.
// Used by the front, the command queue, the engine and the top level.
`timescale 1ns / 1ps

package ipv4ftc_pkg;

  // Table geometry. Keys are spread over banks so that one row of banks is
  // compared per cycle during a lookup.
  localparam int TABLE_ENTRIES = 64;
  localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int NUM_BANKS     = 8;
  localparam int BANK_W        = $clog2(NUM_BANKS);
  localparam int ROWS          = TABLE_ENTRIES / NUM_BANKS;
  localparam int ROW_W         = ENTRY_W - BANK_W;
  localparam int ROW_CNT_W     = $clog2(ROWS + 1);

  // Field widths.
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int ETYPE_W  = 16;
  localparam int PROTO_W  = 8;
  localparam int LEN_W    = 16;
  localparam int STATUS_W = 3;
  localparam int PKT_W    = 32;
  localparam int BYTE_W   = 48;
  localparam int KEY_W    = 2 * ADDR_W + 2 * PORT_W;
  localparam int CWORD_W  = PKT_W + BYTE_W;

  // Command queue depth between the front and the engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Header values that qualify a packet.
  localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;
  localparam logic [PROTO_W-1:0] PROTO_ZERO = 8'd0;

  // Action codes on the input.
  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED    = 3'd0,
    ST_COUNTED    = 3'd1,
    ST_NEW        = 3'd2,
    ST_FULL       = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_READ_EMPTY = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_IGNORE,
    CMD_PACKET,
    CMD_READ
  } cmd_kind_e;

  // One classified request as it travels from the front to the engine.
  typedef struct packed {
    cmd_kind_e          kind;
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_addr;
    logic [PORT_W-1:0]  src_port;
    logic [PORT_W-1:0]  dst_port;
    logic [LEN_W-1:0]   frame_length;
    logic [ENTRY_W-1:0] read_index;
  } cmd_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SEARCH,
    ENG_CNT_RD,
    ENG_CNT_UPD,
    ENG_RD_ISSUE,
    ENG_RD_DATA,
    ENG_OUT
  } eng_state_e;

endpackage

### sv/ipv4ftc_front.sv
// Input stage: accepts a request, classifies it and holds it for the queue.
// Depends on ipv4ftc_pkg.
`timescale 1ns / 1ps

module ipv4ftc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [ipv4ftc_pkg::ETYPE_W-1:0] ether_type_i,
  input  logic [ipv4ftc_pkg::PROTO_W-1:0] ip_protocol_i,
  input  logic [ipv4ftc_pkg::ADDR_W-1:0]  src_addr_i,
  input  logic [ipv4ftc_pkg::ADDR_W-1:0]  dst_addr_i,
  input  logic [ipv4ftc_pkg::PORT_W-1:0]  src_port_i,
  input  logic [ipv4ftc_pkg::PORT_W-1:0]  dst_port_i,
  input  logic [ipv4ftc_pkg::LEN_W-1:0]   frame_length_i,
  input  logic [ipv4ftc_pkg::ENTRY_W-1:0] read_index_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output ipv4ftc_pkg::cmd_t              push_cmd_o
);
  import ipv4ftc_pkg::*;

  logic      hold_q, hold_d;
  cmd_t      cmd_q, cmd_new;
  logic      accept;
  logic      proto_ok;

  // Classify the incoming request.
  always_comb begin
    proto_ok = (ip_protocol_i == PROTO_TCP) || (ip_protocol_i == PROTO_UDP) ||
               (ip_protocol_i == PROTO_ZERO);
    cmd_new.src_addr     = src_addr_i;
    cmd_new.dst_addr     = dst_addr_i;
    cmd_new.src_port     = src_port_i;
    cmd_new.dst_port     = dst_port_i;
    cmd_new.frame_length = frame_length_i;
    cmd_new.read_index   = read_index_i;
    if (action_i == ACT_READ) begin
      cmd_new.kind = CMD_READ;
    end else if ((ether_type_i == ETYPE_IPV4) && proto_ok) begin
      cmd_new.kind = CMD_PACKET;
    end else begin
      cmd_new.kind = CMD_IGNORE;
    end
  end

  // The holding register frees as soon as the queue takes its request.
  assign in_ready_o   = !hold_q || push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = hold_q;
  assign push_cmd_o   = cmd_q;

  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d = 1'b1;
    end else if (push_ready_i) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_new;
    end
  end

endmodule

### sv/ipv4ftc_queue.sv
// Short request queue between the front and the engine.
// Depends on ipv4ftc_pkg.
`timescale 1ns / 1ps

module ipv4ftc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  ipv4ftc_pkg::cmd_t push_cmd_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output ipv4ftc_pkg::cmd_t pop_cmd_o
);
  import ipv4ftc_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### sv/ipv4ftc_engine.sv
// Back end: banked key store, counter store, lookup sequencer and result register.
// Depends on ipv4ftc_pkg.
`timescale 1ns / 1ps

module ipv4ftc_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  ipv4ftc_pkg::cmd_t               q_cmd_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ipv4ftc_pkg::STATUS_W-1:0] status_o,
  output logic [ipv4ftc_pkg::ENTRY_W-1:0]  entry_slot_o,
  output logic [ipv4ftc_pkg::ADDR_W-1:0]   flow_src_addr_o,
  output logic [ipv4ftc_pkg::ADDR_W-1:0]   flow_dst_addr_o,
  output logic [ipv4ftc_pkg::PORT_W-1:0]   flow_src_port_o,
  output logic [ipv4ftc_pkg::PORT_W-1:0]   flow_dst_port_o,
  output logic [ipv4ftc_pkg::PKT_W-1:0]    packets_seen_o,
  output logic [ipv4ftc_pkg::BYTE_W-1:0]   bytes_seen_o
);
  import ipv4ftc_pkg::*;

  // Sequencer and control registers.
  eng_state_e          state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [ROW_CNT_W-1:0] row_q, row_d;
  logic                cmp_v_q, cmp_v_d;
  logic [ROW_W-1:0]    cmp_row_q, cmp_row_d;
  logic [ENTRY_W-1:0]  slot_q, slot_d;

  // Result register.
  status_e             res_status_q, res_status_d;
  logic [ENTRY_W-1:0]  res_slot_q, res_slot_d;
  logic [ADDR_W-1:0]   res_src_addr_q, res_src_addr_d;
  logic [ADDR_W-1:0]   res_dst_addr_q, res_dst_addr_d;
  logic [PORT_W-1:0]   res_src_port_q, res_src_port_d;
  logic [PORT_W-1:0]   res_dst_port_q, res_dst_port_d;
  logic [PKT_W-1:0]    res_pkts_q, res_pkts_d;
  logic [BYTE_W-1:0]   res_bytes_q, res_bytes_d;

  // Memory ports.
  logic [KEY_W-1:0]    key_mem [NUM_BANKS][ROWS];
  logic [KEY_W-1:0]    key_rd_q [NUM_BANKS];
  logic [ROW_W-1:0]    key_rd_row;
  logic                key_wr_en;
  logic [BANK_W-1:0]   key_wr_bank;
  logic [ROW_W-1:0]    key_wr_row;
  logic [KEY_W-1:0]    key_wr_data;

  logic [CWORD_W-1:0]  cnt_mem [TABLE_ENTRIES];
  logic [CWORD_W-1:0]  cnt_rd_q;
  logic [ENTRY_W-1:0]  cnt_rd_addr;
  logic                cnt_wr_en;
  logic [ENTRY_W-1:0]  cnt_wr_addr;
  logic [CWORD_W-1:0]  cnt_wr_data;

  // Lookup and update helpers.
  logic [KEY_W-1:0]    cmd_key;
  logic [NUM_BANKS-1:0] lane_hit;
  logic                hit_any;
  logic [BANK_W-1:0]   hit_lane;
  logic [CNT_W:0]      nrows;
  logic                issue;
  logic [KEY_W-1:0]    sel_key;
  logic [PKT_W-1:0]    pkt_old, pkt_new;
  logic [BYTE_W-1:0]   byte_old, byte_new;
  logic [BYTE_W:0]     byte_sum;

  assign cmd_key = {cmd_q.src_addr, cmd_q.dst_addr, cmd_q.src_port, cmd_q.dst_port};

  // Compare one row of banks against the key; the lowest valid lane wins.
  always_comb begin
    logic [ENTRY_W-1:0] lane_slot;
    hit_lane = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      lane_slot   = {cmp_row_q, BANK_W'(b)};
      lane_hit[b] = (CNT_W'(lane_slot) < used_q) && (key_rd_q[b] == cmd_key);
    end
    for (int b = NUM_BANKS - 1; b >= 0; b--) begin
      if (lane_hit[b]) begin
        hit_lane = BANK_W'(b);
      end
    end
    hit_any = |lane_hit;
  end

  // Rows that hold at least one allocated entry.
  assign nrows = ({1'b0, used_q} + (CNT_W + 1)'(NUM_BANKS - 1)) >> BANK_W;
  assign issue = ((CNT_W + 1)'(row_q) < nrows);

  // Saturating counter update from the stored word.
  always_comb begin
    pkt_old  = cnt_rd_q[CWORD_W-1:BYTE_W];
    byte_old = cnt_rd_q[BYTE_W-1:0];
    pkt_new  = (pkt_old == '1) ? pkt_old : pkt_old + PKT_W'(1);
    byte_sum = {1'b0, byte_old} + (BYTE_W + 1)'(cmd_q.frame_length);
    byte_new = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
  end

  assign sel_key = key_rd_q[slot_q[BANK_W-1:0]];

  // Sequencer: next state, memory controls and result value.
  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    used_d         = used_q;
    row_d          = row_q;
    cmp_v_d        = cmp_v_q;
    cmp_row_d      = cmp_row_q;
    slot_d         = slot_q;
    res_status_d   = res_status_q;
    res_slot_d     = res_slot_q;
    res_src_addr_d = res_src_addr_q;
    res_dst_addr_d = res_dst_addr_q;
    res_src_port_d = res_src_port_q;
    res_dst_port_d = res_dst_port_q;
    res_pkts_d     = res_pkts_q;
    res_bytes_d    = res_bytes_q;
    q_ready_o      = 1'b0;
    key_rd_row     = row_q[ROW_W-1:0];
    key_wr_en      = 1'b0;
    key_wr_bank    = used_q[BANK_W-1:0];
    key_wr_row     = used_q[ENTRY_W-1:BANK_W];
    key_wr_data    = cmd_key;
    cnt_rd_addr    = slot_q;
    cnt_wr_en      = 1'b0;
    cnt_wr_addr    = slot_q;
    cnt_wr_data    = {pkt_new, byte_new};

    case (state_q)
      ENG_IDLE: begin
        if (q_valid_i) begin
          q_ready_o = 1'b1;
          cmd_d     = q_cmd_i;
          row_d     = '0;
          cmp_v_d   = 1'b0;
          slot_d    = q_cmd_i.read_index;
          case (q_cmd_i.kind)
            CMD_PACKET: state_d = ENG_SEARCH;
            CMD_READ:   state_d = ENG_RD_ISSUE;
            default: begin
              res_status_d   = ST_IGNORED;
              res_slot_d     = '0;
              res_src_addr_d = '0;
              res_dst_addr_d = '0;
              res_src_port_d = '0;
              res_dst_port_d = '0;
              res_pkts_d     = '0;
              res_bytes_d    = '0;
              state_d        = ENG_OUT;
            end
          endcase
        end
      end

      ENG_SEARCH: begin
        // Read the next row while the previous one is compared.
        cmp_v_d   = issue;
        cmp_row_d = row_q[ROW_W-1:0];
        if (issue) begin
          row_d = row_q + ROW_CNT_W'(1);
        end
        if (cmp_v_q && hit_any) begin
          slot_d  = {cmp_row_q, hit_lane};
          cmp_v_d = 1'b0;
          state_d = ENG_CNT_RD;
        end else if (!cmp_v_q && !issue) begin
          if (used_q >= CNT_W'(TABLE_ENTRIES)) begin
            // Miss with no free entry: the packet is dropped.
            res_status_d   = ST_FULL;
            res_slot_d     = '0;
            res_src_addr_d = '0;
            res_dst_addr_d = '0;
            res_src_port_d = '0;
            res_dst_port_d = '0;
            res_pkts_d     = '0;
            res_bytes_d    = '0;
          end else begin
            // Miss: allocate the next free entry with its first packet.
            key_wr_en      = 1'b1;
            cnt_wr_en      = 1'b1;
            cnt_wr_addr    = used_q[ENTRY_W-1:0];
            cnt_wr_data    = {PKT_W'(1), BYTE_W'(cmd_q.frame_length)};
            used_d         = used_q + CNT_W'(1);
            res_status_d   = ST_NEW;
            res_slot_d     = used_q[ENTRY_W-1:0];
            res_src_addr_d = cmd_q.src_addr;
            res_dst_addr_d = cmd_q.dst_addr;
            res_src_port_d = cmd_q.src_port;
            res_dst_port_d = cmd_q.dst_port;
            res_pkts_d     = PKT_W'(1);
            res_bytes_d    = BYTE_W'(cmd_q.frame_length);
          end
          state_d = ENG_OUT;
        end
      end

      ENG_CNT_RD: begin
        state_d = ENG_CNT_UPD;
      end

      ENG_CNT_UPD: begin
        // Hit: the stored key equals the request key.
        cnt_wr_en      = 1'b1;
        res_status_d   = ST_COUNTED;
        res_slot_d     = slot_q;
        res_src_addr_d = cmd_q.src_addr;
        res_dst_addr_d = cmd_q.dst_addr;
        res_src_port_d = cmd_q.src_port;
        res_dst_port_d = cmd_q.dst_port;
        res_pkts_d     = pkt_new;
        res_bytes_d    = byte_new;
        state_d        = ENG_OUT;
      end

      ENG_RD_ISSUE: begin
        key_rd_row = slot_q[ENTRY_W-1:BANK_W];
        state_d    = ENG_RD_DATA;
      end

      ENG_RD_DATA: begin
        res_slot_d = slot_q;
        if (CNT_W'(slot_q) < used_q) begin
          res_status_d   = ST_READ_OK;
          res_src_addr_d = sel_key[KEY_W-1 -: ADDR_W];
          res_dst_addr_d = sel_key[2*PORT_W +: ADDR_W];
          res_src_port_d = sel_key[PORT_W +: PORT_W];
          res_dst_port_d = sel_key[PORT_W-1:0];
          res_pkts_d     = cnt_rd_q[CWORD_W-1:BYTE_W];
          res_bytes_d    = cnt_rd_q[BYTE_W-1:0];
        end else begin
          res_status_d   = ST_READ_EMPTY;
          res_src_addr_d = '0;
          res_dst_addr_d = '0;
          res_src_port_d = '0;
          res_dst_port_d = '0;
          res_pkts_d     = '0;
          res_bytes_d    = '0;
        end
        state_d = ENG_OUT;
      end

      ENG_OUT: begin
        if (out_ready_i) begin
          state_d = ENG_IDLE;
        end
      end

      default: begin
        state_d = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ENG_IDLE;
      used_q    <= '0;
      row_q     <= '0;
      cmp_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      row_q     <= row_d;
      cmp_v_q   <= cmp_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q          <= cmd_d;
    cmp_row_q      <= cmp_row_d;
    slot_q         <= slot_d;
    res_status_q   <= res_status_d;
    res_slot_q     <= res_slot_d;
    res_src_addr_q <= res_src_addr_d;
    res_dst_addr_q <= res_dst_addr_d;
    res_src_port_q <= res_src_port_d;
    res_dst_port_q <= res_dst_port_d;
    res_pkts_q     <= res_pkts_d;
    res_bytes_q    <= res_bytes_d;
  end

  // Banked key store: one row of every bank is read each cycle.
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (key_wr_en && (key_wr_bank == BANK_W'(b))) begin
        key_mem[b][key_wr_row] <= key_wr_data;
      end
      key_rd_q[b] <= key_mem[b][key_rd_row];
    end
  end

  // Counter store: packet count above byte count.
  always_ff @(posedge clk_i) begin
    if (cnt_wr_en) begin
      cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    end
    cnt_rd_q <= cnt_mem[cnt_rd_addr];
  end

  assign out_valid_o     = (state_q == ENG_OUT);
  assign status_o        = res_status_q;
  assign entry_slot_o    = res_slot_q;
  assign flow_src_addr_o = res_src_addr_q;
  assign flow_dst_addr_o = res_dst_addr_q;
  assign flow_src_port_o = res_src_port_q;
  assign flow_dst_port_o = res_dst_port_q;
  assign packets_seen_o  = res_pkts_q;
  assign bytes_seen_o    = res_bytes_q;

  // The fill count never runs past the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count exceeds table size");

  // The fill count moves only together with a new-entry result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(used_q) |-> (state_q == ENG_OUT && res_status_q == ST_NEW &&
                          used_q == $past(used_q) + CNT_W'(1)))
    else $error("fill count changed without an allocation");

  // A counted hit always points at an allocated entry with a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_status_q == ST_COUNTED) |->
      (CNT_W'(res_slot_q) < used_q && res_pkts_q != '0))
    else $error("hit result on an unallocated entry");

  // A new entry starts with exactly one packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_status_q == ST_NEW) |-> (res_pkts_q == PKT_W'(1)))
    else $error("new entry does not count its first packet");

endmodule

### sv/ipv4_flow_table_counter.sv
// Top level of the IPv4 flow table counter: front, request queue and engine.
// Depends on ipv4ftc_pkg, ipv4ftc_front, ipv4ftc_queue and ipv4ftc_engine.
//
//   Channel  Handshake               Payload
//   input    in_valid_i/in_ready_o   action, header fields, frame length, read index
//   output   out_valid_o/out_ready_i status, slot, stored key, packet and byte counts
//
// The engine takes one request at a time. A packet lookup scans the occupied rows of 8 keys
// in order; a hit stops at the matching row, while a new entry or a drop scans them all.
// A result waits in the output register while the front and the queue keep taking
// requests. Reset clears the fill count but not the entries; entries are valid below it, so no
// clearing pass is needed.
`timescale 1ns / 1ps

module ipv4_flow_table_counter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [ipv4ftc_pkg::ETYPE_W-1:0]  ether_type_i,
  input  logic [ipv4ftc_pkg::PROTO_W-1:0]  ip_protocol_i,
  input  logic [ipv4ftc_pkg::ADDR_W-1:0]   src_addr_i,
  input  logic [ipv4ftc_pkg::ADDR_W-1:0]   dst_addr_i,
  input  logic [ipv4ftc_pkg::PORT_W-1:0]   src_port_i,
  input  logic [ipv4ftc_pkg::PORT_W-1:0]   dst_port_i,
  input  logic [ipv4ftc_pkg::LEN_W-1:0]    frame_length_i,
  input  logic [ipv4ftc_pkg::ENTRY_W-1:0]  read_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ipv4ftc_pkg::STATUS_W-1:0] status_o,
  output logic [ipv4ftc_pkg::ENTRY_W-1:0]  entry_slot_o,
  output logic [ipv4ftc_pkg::ADDR_W-1:0]   flow_src_addr_o,
  output logic [ipv4ftc_pkg::ADDR_W-1:0]   flow_dst_addr_o,
  output logic [ipv4ftc_pkg::PORT_W-1:0]   flow_src_port_o,
  output logic [ipv4ftc_pkg::PORT_W-1:0]   flow_dst_port_o,
  output logic [ipv4ftc_pkg::PKT_W-1:0]    packets_seen_o,
  output logic [ipv4ftc_pkg::BYTE_W-1:0]   bytes_seen_o
);
  import ipv4ftc_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  // Classify and register each request.
  ipv4ftc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .ether_type_i   (ether_type_i),
    .ip_protocol_i  (ip_protocol_i),
    .src_addr_i     (src_addr_i),
    .dst_addr_i     (dst_addr_i),
    .src_port_i     (src_port_i),
    .dst_port_i     (dst_port_i),
    .frame_length_i (frame_length_i),
    .read_index_i   (read_index_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_cmd_o     (push_cmd)
  );

  // Decouple the front from the engine.
  ipv4ftc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // Lookup, update and result delivery.
  ipv4ftc_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (pop_valid),
    .q_ready_o       (pop_ready),
    .q_cmd_i         (pop_cmd),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .entry_slot_o    (entry_slot_o),
    .flow_src_addr_o (flow_src_addr_o),
    .flow_dst_addr_o (flow_dst_addr_o),
    .flow_src_port_o (flow_src_port_o),
    .flow_dst_port_o (flow_dst_port_o),
    .packets_seen_o  (packets_seen_o),
    .bytes_seen_o    (bytes_seen_o)
  );

endmodule

### tb/tb_ipv4_flow_table_counter.sv
// Self-checking testbench for the IPv4 flow table counter top level.
// Depends on ipv4ftc_pkg and ipv4_flow_table_counter; it keeps its own flow table model.
`timescale 1ns / 1ps

module tb_ipv4_flow_table_counter;
  import ipv4ftc_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int FILL_ITEMS    = 500;
  localparam int FULL_ITEMS    = 1100;
  localparam int QUIET_ITEMS   = 300;
  localparam int SETTLE_CYCLES = 20;

  // One request as the sender presents it.
  typedef struct packed {
    logic               action;
    logic [ETYPE_W-1:0] etype;
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  sa;
    logic [ADDR_W-1:0]  da;
    logic [PORT_W-1:0]  sp;
    logic [PORT_W-1:0]  dp;
    logic [LEN_W-1:0]   len;
    logic [ENTRY_W-1:0] ridx;
  } flow_req_t;

  // One result as the block should return it.
  typedef struct packed {
    status_e            status;
    logic [ENTRY_W-1:0] slot;
    logic [ADDR_W-1:0]  sa;
    logic [ADDR_W-1:0]  da;
    logic [PORT_W-1:0]  sp;
    logic [PORT_W-1:0]  dp;
    logic [PKT_W-1:0]   pkts;
    logic [BYTE_W-1:0]  bytes;
  } flow_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                action_i;
  logic [ETYPE_W-1:0]  ether_type_i;
  logic [PROTO_W-1:0]  ip_protocol_i;
  logic [ADDR_W-1:0]   src_addr_i;
  logic [ADDR_W-1:0]   dst_addr_i;
  logic [PORT_W-1:0]   src_port_i;
  logic [PORT_W-1:0]   dst_port_i;
  logic [LEN_W-1:0]    frame_length_i;
  logic [ENTRY_W-1:0]  read_index_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [ENTRY_W-1:0]  entry_slot_o;
  logic [ADDR_W-1:0]   flow_src_addr_o;
  logic [ADDR_W-1:0]   flow_dst_addr_o;
  logic [PORT_W-1:0]   flow_src_port_o;
  logic [PORT_W-1:0]   flow_dst_port_o;
  logic [PKT_W-1:0]    packets_seen_o;
  logic [BYTE_W-1:0]   bytes_seen_o;

  // Flow table as the testbench expects it to be.
  logic [2*ADDR_W-1:0] flow_addr_key [TABLE_ENTRIES];
  logic [2*PORT_W-1:0] flow_port_key [TABLE_ENTRIES];
  bit                  flow_in_use   [TABLE_ENTRIES];
  logic [PKT_W-1:0]    flow_pkt_cnt  [TABLE_ENTRIES];
  logic [BYTE_W-1:0]   flow_byte_cnt [TABLE_ENTRIES];
  int                  flows_allocated;

  flow_result_t pending_flow_results[$];
  int           mismatch_count;
  int           results_seen;
  int           cycle_count;
  bit           quiet_tail;

  ipv4_flow_table_counter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .ether_type_i   (ether_type_i),
    .ip_protocol_i  (ip_protocol_i),
    .src_addr_i     (src_addr_i),
    .dst_addr_i     (dst_addr_i),
    .src_port_i     (src_port_i),
    .dst_port_i     (dst_port_i),
    .frame_length_i (frame_length_i),
    .read_index_i   (read_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .entry_slot_o   (entry_slot_o),
    .flow_src_addr_o(flow_src_addr_o),
    .flow_dst_addr_o(flow_dst_addr_o),
    .flow_src_port_o(flow_src_port_o),
    .flow_dst_port_o(flow_dst_port_o),
    .packets_seen_o (packets_seen_o),
    .bytes_seen_o   (bytes_seen_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** ipv4_flow_table_counter: FAILED **");
      $finish;
    end
  end

  // Builds the result for a table entry from the expected table contents.
  function automatic flow_result_t entry_result(status_e status, int slot);
    flow_result_t res;
    res        = '0;
    res.status = status;
    res.slot   = slot[ENTRY_W-1:0];
    res.sa     = flow_addr_key[slot][2*ADDR_W-1:ADDR_W];
    res.da     = flow_addr_key[slot][ADDR_W-1:0];
    res.sp     = flow_port_key[slot][2*PORT_W-1:PORT_W];
    res.dp     = flow_port_key[slot][PORT_W-1:0];
    res.pkts   = flow_pkt_cnt[slot];
    res.bytes  = flow_byte_cnt[slot];
    return res;
  endfunction

  // Applies one request to the expected flow table and returns its result.
  function automatic flow_result_t tally_flow(flow_req_t r);
    flow_result_t        res;
    logic [2*ADDR_W-1:0] akey;
    logic [2*PORT_W-1:0] pkey;
    logic [BYTE_W:0]     sum;
    int                  hit;
    res  = '0;
    akey = {r.sa, r.da};
    pkey = {r.sp, r.dp};
    hit  = -1;

    // Reads ignore every field except the index.
    if (r.action == ACT_READ) begin
      if (int'(r.ridx) < TABLE_ENTRIES && flow_in_use[r.ridx]) begin
        return entry_result(ST_READ_OK, int'(r.ridx));
      end
      res.status = ST_READ_EMPTY;
      res.slot   = r.ridx;
      return res;
    end

    // Only IPv4 with TCP, UDP or protocol zero is counted.
    if (r.etype != ETYPE_IPV4 ||
        (r.proto != PROTO_TCP && r.proto != PROTO_UDP && r.proto != PROTO_ZERO)) begin
      res.status = ST_IGNORED;
      return res;
    end

    // Lowest valid matching slot wins.
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && flow_in_use[i] && flow_addr_key[i] == akey && flow_port_key[i] == pkey) begin
        hit = i;
      end
    end

    if (hit >= 0) begin
      if (flow_pkt_cnt[hit] != '1) begin
        flow_pkt_cnt[hit] = flow_pkt_cnt[hit] + PKT_W'(1);
      end
      sum = {1'b0, flow_byte_cnt[hit]} + (BYTE_W + 1)'(r.len);
      flow_byte_cnt[hit] = sum[BYTE_W] ? '1 : sum[BYTE_W-1:0];
      return entry_result(ST_COUNTED, hit);
    end

    if (flows_allocated >= TABLE_ENTRIES) begin
      res.status = ST_FULL;
      return res;
    end

    // Miss with room left: take the next free slot.
    flow_addr_key[flows_allocated] = akey;
    flow_port_key[flows_allocated] = pkey;
    flow_pkt_cnt[flows_allocated]  = PKT_W'(1);
    flow_byte_cnt[flows_allocated] = BYTE_W'(r.len);
    flow_in_use[flows_allocated]   = 1'b1;
    flows_allocated++;
    return entry_result(ST_NEW, flows_allocated - 1);
  endfunction

  function automatic flow_req_t make_packet(logic [ETYPE_W-1:0] etype, logic [PROTO_W-1:0] proto,
                                            logic [ADDR_W-1:0] sa, logic [ADDR_W-1:0] da,
                                            logic [PORT_W-1:0] sp, logic [PORT_W-1:0] dp,
                                            logic [LEN_W-1:0] len);
    flow_req_t r;
    r        = '0;
    r.action = ACT_PACKET;
    r.etype  = etype;
    r.proto  = proto;
    r.sa     = sa;
    r.da     = da;
    r.sp     = sp;
    r.dp     = dp;
    r.len    = len;
    r.ridx   = ENTRY_W'($urandom);
    return r;
  endfunction

  // A read request with random contents in the ignored fields.
  function automatic flow_req_t make_read(logic [ENTRY_W-1:0] idx);
    flow_req_t r;
    r        = make_packet(ETYPE_W'($urandom), PROTO_W'($urandom), $urandom, $urandom,
                           PORT_W'($urandom), PORT_W'($urandom), LEN_W'($urandom));
    r.action = ACT_READ;
    r.ridx   = idx;
    return r;
  endfunction

  function automatic logic [PROTO_W-1:0] pick_protocol();
    case ($urandom_range(0, 2))
      0:       return PROTO_TCP;
      1:       return PROTO_UDP;
      default: return PROTO_ZERO;
    endcase
  endfunction

  // A qualifying packet on a brand new random flow.
  function automatic flow_req_t fresh_flow_packet();
    return make_packet(ETYPE_IPV4, pick_protocol(), $urandom, $urandom,
                       PORT_W'($urandom), PORT_W'($urandom), LEN_W'($urandom));
  endfunction

  // A qualifying packet on a flow that is already in the table.
  function automatic flow_req_t known_flow_packet();
    int slot;
    slot = $urandom_range(0, flows_allocated - 1);
    return make_packet(ETYPE_IPV4, pick_protocol(),
                       flow_addr_key[slot][2*ADDR_W-1:ADDR_W], flow_addr_key[slot][ADDR_W-1:0],
                       flow_port_key[slot][2*PORT_W-1:PORT_W], flow_port_key[slot][PORT_W-1:0],
                       LEN_W'($urandom));
  endfunction

  // A known flow with one bit flipped in one key field, so it must not match.
  function automatic flow_req_t near_miss_packet();
    flow_req_t r;
    r = known_flow_packet();
    case ($urandom_range(0, 3))
      0:       r.sa[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
      1:       r.da[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
      2:       r.sp[$urandom_range(0, PORT_W - 1)] ^= 1'b1;
      default: r.dp[$urandom_range(0, PORT_W - 1)] ^= 1'b1;
    endcase
    return r;
  endfunction

  // Presents one request, holds it until accepted, and records its expected result.
  // Valid is left high after acceptance so back-to-back requests need no extra edge.
  task automatic send_request(input flow_req_t r);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= r.action;
    ether_type_i   <= r.etype;
    ip_protocol_i  <= r.proto;
    src_addr_i     <= r.sa;
    dst_addr_i     <= r.da;
    src_port_i     <= r.sp;
    dst_port_i     <= r.dp;
    frame_length_i <= r.len;
    read_index_i   <= r.ridx;
    do @(posedge clk_i); while (!in_ready_o);
    pending_flow_results.insert(pending_flow_results.size(), tally_flow(r));
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_flow_results.size() != 0);
  endtask

  // One random request from the traffic mix; counted is low for plain noise.
  task automatic send_random_item(output bit counted);
    flow_req_t r;
    int        pick;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 12) begin
      // Noise: either a foreign ethertype or an unsupported protocol.
      r = fresh_flow_packet();
      if ($urandom_range(0, 1)) r.etype = ETYPE_W'($urandom);
      else r.proto = PROTO_W'($urandom);
      counted = 1'b0;
    end else if (pick < 52) begin
      r = known_flow_packet();
    end else if (pick < 67) begin
      r = fresh_flow_packet();
    end else if (pick < 77) begin
      r = near_miss_packet();
    end else begin
      r = make_read(ENTRY_W'($urandom));
    end
    send_request(r);
  endtask

  // Header qualification: foreign ethertypes and unsupported protocols are ignored.
  task automatic test_header_filter();
    send_request(make_packet(16'h0000, PROTO_TCP, '1, '1, '1, '1, '1));
    send_request(make_packet(16'hFFFF, PROTO_UDP, '0, '0, '0, '0, '0));
    send_request(make_packet(16'h0801, PROTO_TCP, 32'h1, 32'h2, 16'h3, 16'h4, 16'h40));
    send_request(make_packet(ETYPE_IPV4, 8'd1, 32'h1, 32'h2, 16'h3, 16'h4, 16'h40));
    send_request(make_packet(ETYPE_IPV4, 8'hFF, 32'h1, 32'h2, 16'h3, 16'h4, 16'h40));
    send_request(make_packet(ETYPE_IPV4, 8'd7, 32'h1, 32'h2, 16'h3, 16'h4, 16'h40));
    send_request(make_packet(ETYPE_IPV4, 8'd16, 32'h1, 32'h2, 16'h3, 16'h4, 16'h40));
    send_request(make_packet(ETYPE_IPV4, 8'd18, 32'h1, 32'h2, 16'h3, 16'h4, 16'h40));
  endtask

  // Allocation and hits with extreme keys and lengths, including keys that differ
  // only in one port.
  task automatic test_new_and_hit();
    send_request(make_packet(ETYPE_IPV4, PROTO_ZERO, '0, '0, '0, '0, '0));
    send_request(make_packet(ETYPE_IPV4, PROTO_TCP, '1, '1, '1, '1, '1));
    send_request(make_packet(ETYPE_IPV4, PROTO_UDP, '1, '1, '1, '1, '1));
    send_request(make_packet(ETYPE_IPV4, PROTO_TCP, '1, '1, '1, 16'hFFFE, 16'h0040));
    send_request(make_packet(ETYPE_IPV4, PROTO_UDP, '0, '0, '0, '0, 16'h0001));
    send_request(make_packet(ETYPE_IPV4, PROTO_UDP, 32'hAAAAAAAA, 32'h55555555,
                             16'h5555, 16'hAAAA, 16'h8000));
    send_request(make_packet(ETYPE_IPV4, PROTO_ZERO, 32'hAAAAAAAA, 32'h55555555,
                             16'h5554, 16'hAAAA, 16'h7FFF));
  endtask

  // Reads of valid and empty entries, with the other fields holding junk.
  task automatic test_table_reads();
    send_request(make_read(6'd0));
    send_request(make_read(6'd3));
    send_request(make_read(6'd63));
    send_request(make_read(6'd1));
    send_request(make_read(6'd40));
  endtask

  // Mixed traffic while the table fills up.
  task automatic test_random_filling();
    int n;
    bit counted;
    n = 0;
    while (n < FILL_ITEMS) begin
      send_random_item(counted);
      if (counted) n++;
    end
  endtask

  // Mixed traffic against a full table; the last stretch runs without idling.
  task automatic test_random_full_table();
    int n;
    bit counted;
    n = 0;
    while (n < FULL_ITEMS) begin
      if (n >= FULL_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      send_random_item(counted);
      if (counted) n++;
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    action_i        <= ACT_PACKET;
    ether_type_i    <= '0;
    ip_protocol_i   <= '0;
    src_addr_i      <= '0;
    dst_addr_i      <= '0;
    src_port_i      <= '0;
    dst_port_i      <= '0;
    frame_length_i  <= '0;
    read_index_i    <= '0;
    mismatch_count  = 0;
    results_seen    = 0;
    quiet_tail      = 1'b0;
    flows_allocated = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      flow_in_use[i]   = 1'b0;
      flow_addr_key[i] = '0;
      flow_port_key[i] = '0;
      flow_pkt_cnt[i]  = '0;
      flow_byte_cnt[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_filter();
    test_new_and_hit();
    test_table_reads();
    // Let the engine run dry once before the random traffic.
    wait_for_results();
    test_random_filling();
    test_random_full_table();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_flow_results.size() == 0) begin
      $display("** ipv4_flow_table_counter: PASSED **");
    end else begin
      $display("** ipv4_flow_table_counter: FAILED **");
    end
    $finish;
  end

  // Result side: ready toggles in random bursts, steady in the final stretch.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!quiet_tail && $urandom_range(0, 1)) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  // Records one field mismatch; only the first few are printed.
  task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
    if (actual !== expected) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("result %0d: %s expected %0h, got %0h", results_seen, name, expected, actual);
      end
    end
  endtask

  // Compares every accepted result with the oldest pending expectation.
  always @(posedge clk_i) begin
    flow_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_flow_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result %0d: no request pending, status %0d", results_seen, status_o);
        end
      end else begin
        want = pending_flow_results.pop_front();
        check_field("status", 64'(want.status), 64'(status_o));
        check_field("entry_slot", 64'(want.slot), 64'(entry_slot_o));
        check_field("flow_src_addr", 64'(want.sa), 64'(flow_src_addr_o));
        check_field("flow_dst_addr", 64'(want.da), 64'(flow_dst_addr_o));
        check_field("flow_src_port", 64'(want.sp), 64'(flow_src_port_o));
        check_field("flow_dst_port", 64'(want.dp), 64'(flow_dst_port_o));
        check_field("packets_seen", 64'(want.pkts), 64'(packets_seen_o));
        check_field("bytes_seen", 64'(want.bytes), 64'(bytes_seen_o));
      end
      results_seen++;
    end
  end

endmodule
